/* rtl/core/zero_crossing_triggered_capture_macros.svh */
// Assertion macros used by the checker of the capture block.
`ifndef ZERO_CROSSING_TRIGGERED_CAPTURE_MACROS_SVH
`define ZERO_CROSSING_TRIGGERED_CAPTURE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ZCTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("zctc: same-cycle property violated");

// Next-cycle implication, disabled while reset is asserted.
`define ZCTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("zctc: next-cycle property violated");

`endif

/* rtl/core/zctc_pkg.sv */
// Shared constants and controller/datapath interface types of the capture block.
package zctc_pkg;

  localparam int BLOCK_LEN   = 256;
  localparam int WAVE_LEN    = 64;
  localparam int ROOM        = BLOCK_LEN - WAVE_LEN;
  localparam int ADDR_W      = $clog2(BLOCK_LEN);
  localparam int SAMPLE_W    = 16;
  localparam int SUM_W       = SAMPLE_W + ADDR_W + 1;
  localparam int WCNT_W      = $clog2(WAVE_LEN + 1);
  localparam int WAVE_W      = 8;
  localparam int IDX_W       = 8;
  localparam int WAVE_CLIP   = 127;
  localparam int DIV_SHIFT   = 5;
  localparam int RECIP       = 683;
  localparam int RECIP_SHIFT = 11;
  localparam int SAMPLE_MAX  = 32767;
  localparam int SAMPLE_MIN  = -32768;

  typedef struct packed {
    logic load;
    logic finish;
    logic scan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic block_full;
    logic scan_done;
    logic emit_done;
  } sts_t;

endpackage

/* rtl/core/zctc_ctrl.sv */
// Controller state machine that sequences loading, trigger search and emission.
module zctc_ctrl import zctc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_FINISH = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0] state_q;
  logic [1:0] state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (sts_i.block_full) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.emit_done) begin
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/zctc_dpath.sv */
// Datapath with the block store, block statistics, trigger search and output scaling.
module zctc_dpath import zctc_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output sts_t                       sts_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic signed [WAVE_W-1:0]   wave_sample_o,
  output logic                       window_last_o,
  output logic signed [SAMPLE_W-1:0] block_dc_o,
  output logic [SAMPLE_W-1:0]        peak_to_peak_o,
  output logic [IDX_W-1:0]           trigger_index_o
);

  logic signed [SAMPLE_W-1:0] mem_q [BLOCK_LEN];
  logic signed [SAMPLE_W-1:0] rdata_q;
  logic [ADDR_W-1:0]          rd_addr;
  logic                       rd_en;

  logic [ADDR_W-1:0]          fill_q, fill_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic signed [SAMPLE_W-1:0] min_q, min_d;
  logic signed [SAMPLE_W-1:0] max_q, max_d;

  logic signed [SAMPLE_W-1:0] dc_q, dc_d;
  logic [SAMPLE_W-1:0]        p2p_q, p2p_d;
  logic signed [SUM_W-1:0]    sum_shift;
  logic signed [SUM_W-1:0]    dc_full;

  logic [ADDR_W-1:0]          idx_q, idx_d;
  logic signed [SAMPLE_W-1:0] prev_q, prev_d;
  logic [ADDR_W-1:0]          start_q, start_d;
  logic                       hit;

  logic [WCNT_W-1:0]          issue_cnt_q, issue_cnt_d;
  logic [WCNT_W-1:0]          out_cnt_q, out_cnt_d;
  logic                       rd_pend_q, rd_pend_d;
  logic                       out_valid_q, out_valid_d;
  logic                       load_out;
  logic                       issue;

  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          mag;
  logic [SAMPLE_W-DIV_SHIFT-1:0] coarse;
  logic [SAMPLE_W-DIV_SHIFT+RECIP_SHIFT-1:0] prod;
  logic [SAMPLE_W-DIV_SHIFT-1:0] quot;
  logic [WAVE_W-1:0]          clipped;
  logic signed [WAVE_W-1:0]   wave_val;

  logic signed [WAVE_W-1:0]   wave_q;
  logic                       last_q;
  logic signed [SAMPLE_W-1:0] odc_q;
  logic [SAMPLE_W-1:0]        op2p_q;
  logic [IDX_W-1:0]           trig_q;

  // Block mean truncated toward zero: arithmetic shift, then round negative values up.
  assign sum_shift = sum_q >>> ADDR_W;
  assign dc_full   = sum_shift + SUM_W'(sum_q[SUM_W-1] & (|sum_q[ADDR_W-1:0]));

  assign hit = (idx_q != '0) && (prev_q <= dc_q) && (rdata_q > dc_q);

  assign load_out = cmd_i.emit && rd_pend_q && (!out_valid_q || out_ready_i);
  assign issue    = cmd_i.emit && (issue_cnt_q != WCNT_W'(WAVE_LEN)) &&
                    (!rd_pend_q || load_out);

  assign sts_o.block_full = cmd_i.load && (fill_q == ADDR_W'(BLOCK_LEN - 1));
  assign sts_o.scan_done  = cmd_i.scan && (hit || (idx_q == ADDR_W'(ROOM - 1)));
  assign sts_o.emit_done  = load_out && (out_cnt_q == WCNT_W'(WAVE_LEN - 1));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd_i.finish) begin
      rd_en = 1'b1;
    end else if (cmd_i.scan) begin
      rd_en   = 1'b1;
      rd_addr = idx_q + ADDR_W'(1);
    end else if (issue) begin
      rd_en   = 1'b1;
      rd_addr = start_q + ADDR_W'(issue_cnt_q);
    end
  end

  // Division by 96 as a shift by 32 followed by a reciprocal multiply for 3.
  always_comb begin
    diff     = {rdata_q[SAMPLE_W-1], rdata_q} - {dc_q[SAMPLE_W-1], dc_q};
    mag      = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
    coarse   = mag[SAMPLE_W-1:DIV_SHIFT];
    prod     = coarse * (SAMPLE_W-DIV_SHIFT+RECIP_SHIFT)'(RECIP);
    quot     = prod[SAMPLE_W-DIV_SHIFT+RECIP_SHIFT-1:RECIP_SHIFT];
    clipped  = (quot > (SAMPLE_W-DIV_SHIFT)'(WAVE_CLIP)) ? WAVE_W'(WAVE_CLIP)
                                                         : WAVE_W'(quot);
    wave_val = diff[SAMPLE_W] ? -$signed(clipped) : $signed(clipped);
  end

  always_comb begin
    fill_d      = fill_q;
    sum_d       = sum_q;
    min_d       = min_q;
    max_d       = max_q;
    dc_d        = dc_q;
    p2p_d       = p2p_q;
    idx_d       = idx_q;
    prev_d      = prev_q;
    start_d     = start_q;
    issue_cnt_d = issue_cnt_q;
    out_cnt_d   = out_cnt_q;
    rd_pend_d   = rd_pend_q;
    out_valid_d = out_valid_q;

    if (cmd_i.load) begin
      fill_d = fill_q + ADDR_W'(1);
      sum_d  = sum_q + {{(SUM_W-SAMPLE_W){sample_i[SAMPLE_W-1]}}, sample_i};
      if (sample_i < min_q) begin
        min_d = sample_i;
      end
      if (sample_i > max_q) begin
        max_d = sample_i;
      end
    end

    if (cmd_i.finish) begin
      dc_d   = dc_full[SAMPLE_W-1:0];
      p2p_d  = SAMPLE_W'(max_q - min_q);
      fill_d = '0;
      sum_d  = '0;
      min_d  = SAMPLE_W'(SAMPLE_MAX);
      max_d  = SAMPLE_W'(SAMPLE_MIN);
      idx_d  = '0;
    end

    if (cmd_i.scan) begin
      prev_d = rdata_q;
      idx_d  = idx_q + ADDR_W'(1);
      if (sts_o.scan_done) begin
        start_d     = hit ? idx_q : '0;
        issue_cnt_d = '0;
        out_cnt_d   = '0;
        rd_pend_d   = 1'b0;
      end
    end

    if (issue) begin
      issue_cnt_d = issue_cnt_q + WCNT_W'(1);
      rd_pend_d   = 1'b1;
    end else if (load_out) begin
      rd_pend_d = 1'b0;
    end

    if (load_out) begin
      out_cnt_d   = out_cnt_q + WCNT_W'(1);
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem_q[fill_q] <= sample_i;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      sum_q       <= '0;
      min_q       <= SAMPLE_W'(SAMPLE_MAX);
      max_q       <= SAMPLE_W'(SAMPLE_MIN);
      idx_q       <= '0;
      issue_cnt_q <= '0;
      out_cnt_q   <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      min_q       <= min_d;
      max_q       <= max_d;
      idx_q       <= idx_d;
      issue_cnt_q <= issue_cnt_d;
      out_cnt_q   <= out_cnt_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dc_q    <= dc_d;
    p2p_q   <= p2p_d;
    prev_q  <= prev_d;
    start_q <= start_d;
    if (load_out) begin
      wave_q <= wave_val;
      last_q <= (out_cnt_q == WCNT_W'(WAVE_LEN - 1));
      odc_q  <= dc_q;
      op2p_q <= p2p_q;
      trig_q <= IDX_W'(start_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign wave_sample_o   = wave_q;
  assign window_last_o   = last_q;
  assign block_dc_o      = odc_q;
  assign peak_to_peak_o  = op2p_q;
  assign trigger_index_o = trig_q;

endmodule

/* rtl/core/zero_crossing_triggered_capture.sv */
// Top level of the rising zero-crossing triggered capture block.
// Each sample transfer is written into a 256-entry block store while the block sum,
// minimum and maximum are updated. After the 256th sample the block no longer accepts
// input: a finish step forms the mean and peak-to-peak value, the trigger search then
// reads the store one entry per cycle, and the 64-sample window follows at one result
// per cycle while the output is not stalled, each read of the store being registered.
// The store has a single read port, used in turn by the finish step, the trigger search
// and the window read-out. The last result of a window may still wait in the output
// register while the next block begins to load.
module zero_crossing_triggered_capture import zctc_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [WAVE_W-1:0]   wave_sample_o,
  output logic                       window_last_o,
  output logic signed [SAMPLE_W-1:0] block_dc_o,
  output logic [SAMPLE_W-1:0]        peak_to_peak_o,
  output logic [IDX_W-1:0]           trigger_index_o
);

  cmd_t cmd;
  sts_t sts;

  zctc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  zctc_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .sample_i        (sample_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .wave_sample_o   (wave_sample_o),
    .window_last_o   (window_last_o),
    .block_dc_o      (block_dc_o),
    .peak_to_peak_o  (peak_to_peak_o),
    .trigger_index_o (trigger_index_o)
  );

endmodule

/* rtl/core/zctc_checker.sv */
// Port-level checker of the capture block and its bind to the top level.
`include "zero_crossing_triggered_capture_macros.svh"

module zctc_checker import zctc_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic signed [SAMPLE_W-1:0] sample_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [WAVE_W-1:0]   wave_sample_o,
  input logic                       window_last_o,
  input logic signed [SAMPLE_W-1:0] block_dc_o,
  input logic [SAMPLE_W-1:0]        peak_to_peak_o,
  input logic [IDX_W-1:0]           trigger_index_o
);

  // No sample transfer is taken while a window is only partly delivered.
  `ZCTC_ASSERT_IMP(a_no_input_mid_window, clk_i, rst_ni, out_valid_o && !window_last_o, !in_ready_o)

  `ZCTC_ASSERT_IMP(a_wave_in_range, clk_i, rst_ni, out_valid_o, wave_sample_o != 8'sh80)

  `ZCTC_ASSERT_IMP(a_trigger_in_room, clk_i, rst_ni, out_valid_o, int'(trigger_index_o) < ROOM)

  `ZCTC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(wave_sample_o) && $stable(window_last_o) && $stable(block_dc_o) && $stable(peak_to_peak_o))

endmodule

bind zero_crossing_triggered_capture zctc_checker u_zctc_checker (.*);
